// ----- hdl/tesp_pkg.sv -----
package tesp_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATE_W  = 4;
    localparam int EXIT_W   = 2;
    localparam int EVENT_W  = 4;
    localparam int ENTRY_W  = 2;
    localparam int RES_W    = BYTE_W + EXIT_W + EVENT_W + ENTRY_W + STATE_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // parser states
    localparam logic [STATE_W-1:0] ST_GROUND    = 4'd0;
    localparam logic [STATE_W-1:0] ST_ESC       = 4'd1;
    localparam logic [STATE_W-1:0] ST_ESC_INT   = 4'd2;
    localparam logic [STATE_W-1:0] ST_CSI_ENTRY = 4'd3;
    localparam logic [STATE_W-1:0] ST_CSI_PARAM = 4'd4;
    localparam logic [STATE_W-1:0] ST_CSI_INT   = 4'd5;
    localparam logic [STATE_W-1:0] ST_CSI_IGN   = 4'd6;
    localparam logic [STATE_W-1:0] ST_DCS_ENTRY = 4'd7;
    localparam logic [STATE_W-1:0] ST_DCS_PARAM = 4'd8;
    localparam logic [STATE_W-1:0] ST_DCS_INT   = 4'd9;
    localparam logic [STATE_W-1:0] ST_DCS_IGN   = 4'd10;
    localparam logic [STATE_W-1:0] ST_DCS_PASS  = 4'd11;
    localparam logic [STATE_W-1:0] ST_OSC       = 4'd12;
    localparam logic [STATE_W-1:0] ST_SOS       = 4'd13;

    // exit actions
    localparam logic [EXIT_W-1:0] EX_NONE    = 2'd0;
    localparam logic [EXIT_W-1:0] EX_OSC_END = 2'd1;
    localparam logic [EXIT_W-1:0] EX_UNHOOK  = 2'd2;

    // event actions
    localparam logic [EVENT_W-1:0] EV_NONE         = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PRINT        = 4'd1;
    localparam logic [EVENT_W-1:0] EV_EXECUTE      = 4'd2;
    localparam logic [EVENT_W-1:0] EV_COLLECT      = 4'd3;
    localparam logic [EVENT_W-1:0] EV_PARAM        = 4'd4;
    localparam logic [EVENT_W-1:0] EV_ESC_DISPATCH = 4'd5;
    localparam logic [EVENT_W-1:0] EV_CSI_DISPATCH = 4'd6;
    localparam logic [EVENT_W-1:0] EV_PUT          = 4'd7;
    localparam logic [EVENT_W-1:0] EV_OSC_PUT      = 4'd8;

    // entry actions
    localparam logic [ENTRY_W-1:0] EN_NONE      = 2'd0;
    localparam logic [ENTRY_W-1:0] EN_CLEAR     = 2'd1;
    localparam logic [ENTRY_W-1:0] EN_OSC_START = 2'd2;
    localparam logic [ENTRY_W-1:0] EN_HOOK      = 2'd3;

    // bytes with a fixed meaning
    localparam logic [BYTE_W-1:0] C_CAN = 8'h18;
    localparam logic [BYTE_W-1:0] C_SUB = 8'h1a;
    localparam logic [BYTE_W-1:0] C_ESC = 8'h1b;
    localparam logic [BYTE_W-1:0] C_DCS = 8'h90;
    localparam logic [BYTE_W-1:0] C_ST  = 8'h9c;
    localparam logic [BYTE_W-1:0] C_CSI = 8'h9b;
    localparam logic [BYTE_W-1:0] C_OSC = 8'h9d;
    localparam logic [BYTE_W-1:0] C_ESC_CSI = 8'h5b;
    localparam logic [BYTE_W-1:0] C_ESC_DCS = 8'h50;
    localparam logic [BYTE_W-1:0] C_ESC_OSC = 8'h5d;

    typedef struct packed {
        logic [EXIT_W-1:0]  exit_action;
        logic [EVENT_W-1:0] event_action;
        logic [ENTRY_W-1:0] entry_action;
        logic [STATE_W-1:0] next_state;
    } act_t;

    function automatic logic [EXIT_W-1:0] exit_of(input logic [STATE_W-1:0] s);
        logic [EXIT_W-1:0] r;
        r = EX_NONE;
        if (s == ST_OSC)
            r = EX_OSC_END;
        else if (s == ST_DCS_PASS)
            r = EX_UNHOOK;
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] entry_of(input logic [STATE_W-1:0] s);
        logic [ENTRY_W-1:0] r;
        r = EN_NONE;
        if (s == ST_ESC || s == ST_CSI_ENTRY || s == ST_DCS_ENTRY)
            r = EN_CLEAR;
        else if (s == ST_OSC)
            r = EN_OSC_START;
        else if (s == ST_DCS_PASS)
            r = EN_HOOK;
        return r;
    endfunction

endpackage

// ----- hdl/terminal_escape_sequence_parser.sv -----
// channel | dir | width | fields (lowest bit up)
// s_*     | in  | 8     | byte_in[7:0]
// m_*     | out | 24    | byte_out[7:0] exit_action[9:8] event_action[13:10]
//         |     |       | entry_action[15:14] next_state[19:16] zero[23:20]
//
// one word per cycle sustained while m_tready holds; each byte sits in the input register,
// where the transition table works on it against the parser state
// an accepted byte is held in the input register; its result is then registered in the output register
// rst_n clears the valid flags and puts the parser in ground
// a stalled result holds in the output register while the input register still
// takes one more word, so the input side backs up only when both are full
module terminal_escape_sequence_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tesp_pkg::BYTE_W-1:0]   s_tdata,   // byte_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tesp_pkg::M_DATA_W-1:0] m_tdata    // byte_out, exit, event, entry, state
);
    import tesp_pkg::*;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;

    // parser state, follows the word last moved to the output
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    act_t               out_act_reg;

    act_t               act;
    logic               advance;   // word moves from input to output register

    tesp_decode u_decode (
        .state   (state_reg),
        .byte_in (in_byte_reg),
        .act     (act)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);
    assign state_next     = advance ? act.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_GROUND;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance)
        begin
            out_byte_reg <= in_byte_reg;
            out_act_reg  <= act;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}},
                       out_act_reg.next_state,
                       out_act_reg.entry_action,
                       out_act_reg.event_action,
                       out_act_reg.exit_action,
                       out_byte_reg};

    // held result always carries the current parser state
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_act_reg.next_state == state_reg)
        else $error("result state differs from parser state");

    // input side stalls only with both registers full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room available");

    // dispatches always return to ground
    a_dispatch_ground: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (act.event_action == EV_ESC_DISPATCH
                    || act.event_action == EV_CSI_DISPATCH)
        |-> act.next_state == ST_GROUND)
        else $error("dispatch without return to ground");

    // clear entry only into escape, csi entry or dcs entry
    a_clear_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && act.entry_action == EN_CLEAR
        |-> act.next_state == ST_ESC || act.next_state == ST_CSI_ENTRY
            || act.next_state == ST_DCS_ENTRY)
        else $error("clear entry into wrong state");

    // a state update without a word moving is a slip
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without a word");

endmodule

// ----- hdl/tesp_decode.sv -----
module tesp_decode (
    input  logic [tesp_pkg::STATE_W-1:0] state,
    input  logic [tesp_pkg::BYTE_W-1:0]  byte_in,
    output tesp_pkg::act_t               act
);
    import tesp_pkg::*;

    function automatic logic in_rng(input logic [BYTE_W-1:0] v,
                                    input logic [BYTE_W-1:0] lo,
                                    input logic [BYTE_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    logic               is_exec;
    logic               any_hit;
    logic [STATE_W-1:0] any_tgt;
    logic [STATE_W-1:0] n;
    logic [EVENT_W-1:0] ev;
    logic               p_digit;   // 0-9 or ;
    logic               p_priv;    // < = > ?
    logic               c_inter;   // 0x20-0x2f
    logic               c_final;   // 0x40-0x7e

    assign is_exec = in_rng(byte_in, 8'h00, 8'h17) || byte_in == 8'h19
                     || in_rng(byte_in, 8'h1c, 8'h1f);
    assign p_digit = in_rng(byte_in, 8'h30, 8'h39) || byte_in == 8'h3b;
    assign p_priv  = in_rng(byte_in, 8'h3c, 8'h3f);
    assign c_inter = in_rng(byte_in, 8'h20, 8'h2f);
    assign c_final = in_rng(byte_in, 8'h40, 8'h7e);

    // rules that apply from any state
    always_comb
    begin
        any_hit = 1'b1;
        any_tgt = ST_GROUND;
        if (byte_in == C_CAN || byte_in == C_SUB || in_rng(byte_in, 8'h80, 8'h8f)
            || in_rng(byte_in, 8'h91, 8'h97) || byte_in == 8'h9a || byte_in == C_ST)
            any_tgt = ST_GROUND;
        else if (byte_in == 8'h98 || byte_in == 8'h9e || byte_in == 8'h9f)
            any_tgt = ST_SOS;
        else if (byte_in == C_ESC)
            any_tgt = ST_ESC;
        else if (byte_in == C_DCS)
            any_tgt = ST_DCS_ENTRY;
        else if (byte_in == C_CSI)
            any_tgt = ST_CSI_ENTRY;
        else if (byte_in == C_OSC)
            any_tgt = ST_OSC;
        else
            any_hit = 1'b0;
    end

    // per-state rules
    always_comb
    begin
        n  = state;
        ev = EV_NONE;
        case (state)
            ST_GROUND:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (in_rng(byte_in, 8'h20, 8'h7f))
                    ev = EV_PRINT;
            end
            ST_ESC:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (byte_in == 8'h58 || byte_in == 8'h5e || byte_in == 8'h5f)
                    n = ST_SOS;
                else if (byte_in == C_ESC_DCS)
                    n = ST_DCS_ENTRY;
                else if (byte_in == C_ESC_CSI)
                    n = ST_CSI_ENTRY;
                else if (byte_in == C_ESC_OSC)
                    n = ST_OSC;
                else if (c_inter)
                begin
                    ev = EV_COLLECT;
                    n  = ST_ESC_INT;
                end
                else if (in_rng(byte_in, 8'h30, 8'h7e))
                begin
                    ev = EV_ESC_DISPATCH;
                    n  = ST_GROUND;
                end
            end
            ST_ESC_INT:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (c_inter)
                    ev = EV_COLLECT;
                else if (in_rng(byte_in, 8'h30, 8'h7e))
                begin
                    ev = EV_ESC_DISPATCH;
                    n  = ST_GROUND;
                end
            end
            ST_CSI_ENTRY:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (p_priv)
                begin
                    ev = EV_COLLECT;
                    n  = ST_CSI_PARAM;
                end
                else if (p_digit)
                begin
                    ev = EV_PARAM;
                    n  = ST_CSI_PARAM;
                end
                else if (byte_in == 8'h3a)
                    n = ST_CSI_IGN;
                else if (c_inter)
                begin
                    ev = EV_COLLECT;
                    n  = ST_CSI_INT;
                end
                else if (c_final)
                begin
                    ev = EV_CSI_DISPATCH;
                    n  = ST_GROUND;
                end
            end
            ST_CSI_PARAM:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (p_digit)
                    ev = EV_PARAM;
                else if (c_final)
                begin
                    ev = EV_CSI_DISPATCH;
                    n  = ST_GROUND;
                end
                else if (c_inter)
                begin
                    ev = EV_COLLECT;
                    n  = ST_CSI_INT;
                end
                else if (byte_in == 8'h3a || p_priv)
                    n = ST_CSI_IGN;
            end
            ST_CSI_INT:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (c_inter)
                    ev = EV_COLLECT;
                else if (in_rng(byte_in, 8'h30, 8'h3f))
                    n = ST_CSI_IGN;
                else if (c_final)
                begin
                    ev = EV_CSI_DISPATCH;
                    n  = ST_GROUND;
                end
            end
            ST_CSI_IGN:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (c_final)
                    n = ST_GROUND;
            end
            ST_DCS_ENTRY:
            begin
                if (is_exec)
                    ev = EV_EXECUTE;
                else if (c_inter)
                begin
                    ev = EV_COLLECT;
                    n  = ST_DCS_INT;
                end
                else if (p_priv)
                begin
                    ev = EV_COLLECT;
                    n  = ST_DCS_PARAM;
                end
                else if (p_digit)
                begin
                    ev = EV_PARAM;
                    n  = ST_DCS_PARAM;
                end
                else if (byte_in == 8'h3a)
                    n = ST_DCS_IGN;
                else if (c_final)
                    n = ST_DCS_PASS;
            end
            ST_DCS_PARAM:
            begin
                if (p_digit)
                    ev = EV_PARAM;
                else if (byte_in == 8'h3a || p_priv)
                    n = ST_DCS_IGN;
                else if (c_inter)
                begin
                    ev = EV_COLLECT;
                    n  = ST_DCS_INT;
                end
                else if (c_final)
                    n = ST_DCS_PASS;
            end
            ST_DCS_INT:
            begin
                if (c_inter)
                    ev = EV_COLLECT;
                else if (in_rng(byte_in, 8'h30, 8'h3f))
                    n = ST_DCS_IGN;
                else if (c_final)
                    n = ST_DCS_PASS;
            end
            ST_DCS_PASS:
            begin
                if (is_exec || in_rng(byte_in, 8'h20, 8'h7e))
                    ev = EV_PUT;
            end
            ST_OSC:
            begin
                if (in_rng(byte_in, 8'h20, 8'h7f))
                    ev = EV_OSC_PUT;
            end
            default:
            begin
                n  = state;
                ev = EV_NONE;
            end
        endcase
    end

    // anywhere rules re-enter even the current state
    always_comb
    begin
        if (any_hit)
        begin
            act.next_state   = any_tgt;
            act.event_action = EV_NONE;
            act.exit_action  = exit_of(state);
            act.entry_action = entry_of(any_tgt);
        end
        else
        begin
            act.next_state   = n;
            act.event_action = ev;
            act.exit_action  = (n != state) ? exit_of(state) : EX_NONE;
            act.entry_action = (n != state) ? entry_of(n) : EN_NONE;
        end
    end

endmodule
